// ===== rtl/core/ttf_pkg.sv =====
// Shared constants, types and helpers for the teletype text formatter.
package ttf_pkg;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_UP     = 8'h5E;
    localparam logic [7:0] CHAR_RUBOUT = 8'h7F;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] HIGH_TOP    = 8'hC0;
    localparam logic [7:0] HIGH_BOTTOM = 8'h80;
    localparam logic [7:0] WIDTH_RESET = 8'd72;

    localparam int unsigned MAX_BYTES = 4;
    localparam int unsigned CNT_W     = 3;

    typedef enum logic {
        OP_RAW  = 1'b0,
        OP_TEXT = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic [7:0]                column;
    } fmt_t;

    function automatic logic [7:0] even_parity(input logic [7:0] v);
        logic [6:0] r;
        r = v[6:0];
        return {^r, r};
    endfunction

    function automatic logic [7:0] column_step(input logic [7:0] col,
                                               input logic [7:0] v,
                                               input logic [7:0] width);
        logic [6:0] c;
        c = v[6:0];
        if (c == CHAR_CR[6:0]) begin
            return 8'd0;
        end else if (c >= CHAR_SPACE[6:0] && c < CHAR_RUBOUT[6:0] && col < width) begin
            return col + 8'd1;
        end else begin
            return col;
        end
    endfunction

endpackage

// ===== rtl/core/teletype_text_formatter.sv =====
// Top level of the teletype text formatter.
//
// Takes one request per cycle into an input register while s_tready is high;
// each request yields one to four bytes (one in raw mode, up to three in text
// mode, four for a line feed with the width at zero), which leave one per cycle
// from the result buffer while m_tready is high. The next request is taken while
// the last byte of the previous one is sent. The line width register is written
// by cfg_we/cfg_wdata; the user must write it only while no request is pending,
// which the block does not enforce. It resets to 72 and the print column to zero.
module teletype_text_formatter
    import ttf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    opcode_t    in_op_reg;
    logic [7:0] width_reg;
    logic [7:0] column_reg, column_next;
    logic       load_ok;
    logic       load;
    fmt_t       fmt;

    assign load     = in_valid_reg && load_ok;
    assign s_tready = !in_valid_reg || load_ok;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
        column_next = load ? fmt.column : column_reg;
    end

    ttf_format u_format (
        .opcode     (in_op_reg),
        .data_byte  (in_data_reg),
        .column     (column_reg),
        .line_width (width_reg),
        .fmt        (fmt)
    );

    ttf_out_seq u_out_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .fmt      (fmt),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_op_reg   <= opcode_t'(s_tuser);
        end
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            width_reg    <= WIDTH_RESET;
            column_reg   <= 8'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            column_reg   <= column_next;
            if (cfg_we) begin
                width_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== rtl/core/ttf_format.sv =====
// Per-request byte mapping, parity, line-break insertion and column update.
module ttf_format
    import ttf_pkg::*;
(
    input  opcode_t    opcode,
    input  logic [7:0] data_byte,
    input  logic [7:0] column,
    input  logic [7:0] line_width,
    output fmt_t       fmt
);

    logic [7:0] mapped;
    logic [7:0] first;
    logic [7:0] col_first;
    logic [7:0] col_lf;
    logic       is_lf;
    logic       force_break;

    always_comb begin
        if (data_byte >= HIGH_TOP) begin
            mapped = CHAR_UP;
        end else if (data_byte >= HIGH_BOTTOM) begin
            mapped = CHAR_RUBOUT;
        end else begin
            mapped = data_byte;
        end
    end

    assign first       = (opcode == OP_TEXT) ? even_parity(mapped) : data_byte;
    assign col_first   = column_step(column, first, line_width);
    assign is_lf       = (mapped == CHAR_LF);
    assign col_lf      = is_lf ? 8'd0 : col_first;
    assign force_break = (col_lf >= line_width);

    always_comb begin
        fmt.bytes[0] = first;
        fmt.bytes[1] = even_parity(CHAR_CR);
        fmt.bytes[2] = even_parity(CHAR_CR);
        fmt.bytes[3] = even_parity(CHAR_LF);
        fmt.count    = CNT_W'(1);
        fmt.column   = col_first;
        if (opcode == OP_TEXT) begin
            if (is_lf && force_break) begin
                fmt.count  = CNT_W'(4);
                fmt.column = 8'd0;
            end else if (is_lf) begin
                fmt.count  = CNT_W'(2);
                fmt.column = 8'd0;
            end else if (force_break) begin
                fmt.bytes[1] = even_parity(CHAR_CR);
                fmt.bytes[2] = even_parity(CHAR_LF);
                fmt.count    = CNT_W'(3);
                fmt.column   = 8'd0;
            end
        end
    end

endmodule

// ===== rtl/core/ttf_out_seq.sv =====
// Result buffer that sends the bytes of one request, one per cycle while m_tready is high.
module ttf_out_seq
    import ttf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  fmt_t       fmt,
    output logic       load_ok,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic [MAX_BYTES-1:0][7:0] bytes_reg, bytes_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      pop;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = bytes_reg[0];
    assign m_tlast  = (cnt_reg == CNT_W'(1));
    assign pop      = m_tvalid && m_tready;
    assign load_ok  = (cnt_reg == '0) || (m_tlast && m_tready);

    always_comb begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        if (load) begin
            bytes_next = fmt.bytes;
            cnt_next   = fmt.count;
        end else if (pop) begin
            bytes_next = {8'd0, bytes_reg[MAX_BYTES-1:1]};
            cnt_next   = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== tb/teletype_text_formatter_tb.sv =====
// Self-checking testbench for the teletype text formatter: stream traffic, checked byte by byte.
`timescale 1ns / 100ps

module teletype_text_formatter_tb;
    import ttf_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int REPORT_MAX   = 10;
    localparam int IDLE_PCT     = 16;
    localparam int PHASE_ITEMS  = 42;
    localparam int HOLD_CYCLES  = 150;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } tty_byte_t;

    class tty_line_tracker;
        logic [7:0] line_width;
        logic [7:0] column;
        tty_byte_t  burst[$];
        tty_byte_t  pending_bytes[$];
        int         mismatch_count;

        function new();
            line_width     = WIDTH_RESET;
            column         = 8'd0;
            mismatch_count = 0;
        endfunction

        function void set_width(logic [7:0] w);
            line_width = w;
        endfunction

        function logic [7:0] with_parity(logic [7:0] v);
            logic p;
            p = ^v[6:0];
            return {p, v[6:0]};
        endfunction

        function void emit_byte(logic [7:0] v);
            logic [6:0] c;
            c = v[6:0];
            burst.push_back('{out_byte: v, last: 1'b0});
            if (c == CHAR_CR[6:0]) begin
                column = 8'd0;
            end else if (c >= CHAR_SPACE[6:0] && c != CHAR_RUBOUT[6:0]
                         && column < line_width) begin
                column = column + 8'd1;
            end
        endfunction

        function void note_request(opcode_t op, logic [7:0] b);
            logic [7:0] glyph;
            burst.delete();
            if (op == OP_RAW) begin
                emit_byte(b);
            end else begin
                if (b >= HIGH_TOP) begin
                    glyph = CHAR_UP;
                end else if (b >= HIGH_BOTTOM) begin
                    glyph = CHAR_RUBOUT;
                end else begin
                    glyph = b;
                end
                emit_byte(with_parity(glyph));
                if (glyph == CHAR_LF) begin
                    emit_byte(with_parity(CHAR_CR));
                end
                if (column >= line_width) begin
                    emit_byte(with_parity(CHAR_CR));
                    emit_byte(with_parity(CHAR_LF));
                end
            end
            burst[burst.size()-1].last = 1'b1;
            foreach (burst[i]) begin
                pending_bytes.push_back(burst[i]);
            end
        endfunction

        function void note_mismatch(string what);
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
                $display("mismatch at %0t: %s", $time, what);
            end
        endfunction

        function void check_byte(logic [7:0] b, logic last);
            tty_byte_t want;
            if (pending_bytes.size() == 0) begin
                note_mismatch($sformatf("unexpected byte %02h last %0b", b, last));
            end else begin
                want = pending_bytes.pop_front();
                if (want.out_byte !== b || want.last !== last) begin
                    note_mismatch($sformatf("expected byte %02h last %0b, got %02h last %0b",
                                            want.out_byte, want.last, b, last));
                end
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    tty_line_tracker book;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;
    int hold_left;
    int cycle_count;

    teletype_text_formatter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("** teletype_text_formatter: FAILED **");
            $finish;
        end
    end

    // receive side: check accepted bytes, then pick the next ready
    initial begin
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                book.check_byte(m_tdata, m_tlast);
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    task automatic send_request(input opcode_t op, input logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        book.note_request(op, b);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (book.pending() > 0);
    endtask

    task automatic write_line_width(input logic [7:0] w);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we <= 1'b0;
        book.set_width(w);
    endtask

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_request(OP_TEXT, 8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 65) begin
            send_request(OP_TEXT, CHAR_LF);
        end else if (pick < 80) begin
            send_request(OP_TEXT, 8'($urandom_range(0, 255)));
        end else if (pick < 85) begin
            send_request(OP_RAW, CHAR_CR);
        end else begin
            send_request(OP_RAW, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [7:0] widths[6];
        book        = new();
        cycle_count = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        hold_req    = 1'b0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 8'd0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tuser     = OP_RAW;
        m_tready    = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, mapping ranges and raw bytes at the reset width
        send_request(OP_TEXT, 8'h00);
        send_request(OP_TEXT, 8'hFF);
        send_request(OP_TEXT, HIGH_TOP);
        send_request(OP_TEXT, 8'hBF);
        send_request(OP_TEXT, HIGH_BOTTOM);
        send_request(OP_TEXT, CHAR_RUBOUT);
        send_request(OP_TEXT, 8'h7E);
        send_request(OP_TEXT, CHAR_SPACE);
        send_request(OP_TEXT, 8'h1F);
        send_request(OP_RAW, 8'hFF);
        send_request(OP_RAW, 8'hA0);
        send_request(OP_RAW, 8'h00);

        // lower the width below the column
        write_line_width(8'd2);
        send_request(OP_TEXT, 8'h41);
        send_request(OP_TEXT, CHAR_LF);
        send_request(OP_TEXT, 8'h8A);
        send_request(OP_RAW, 8'h8D);
        send_request(OP_RAW, CHAR_CR);
        send_request(OP_TEXT, 8'h55);
        send_request(OP_TEXT, 8'h2A);

        write_line_width(8'd1);
        send_request(OP_TEXT, 8'h42);
        send_request(OP_TEXT, CHAR_LF);
        send_request(OP_TEXT, 8'hD5);

        widths[0] = 8'd255;
        widths[1] = 8'd1;
        widths[2] = 8'($urandom_range(2, 20));
        widths[3] = WIDTH_RESET;
        widths[4] = 8'($urandom_range(21, 254));
        widths[5] = 8'($urandom_range(3, 8));

        foreach (widths[p]) begin
            write_line_width(widths[p]);
            tx_idle_on = (p != 2 && p != 3);
            rx_idle_on = (p != 2);
            if (p == 3) begin
                hold_req = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 0 && i == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                send_random_request();
            end
        end

        wait_drained();
        repeat (16) @(posedge aclk);
        if (book.mismatch_count == 0 && book.pending() == 0) begin
            $display("** teletype_text_formatter: PASSED **");
        end else begin
            $display("** teletype_text_formatter: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ttf_pkg.sv
rtl/core/ttf_format.sv
rtl/core/ttf_out_seq.sv
rtl/core/teletype_text_formatter.sv
tb/teletype_text_formatter_tb.sv
